// ===== sv/mbsc_pkg.sv =====
// mbsc_pkg: shared types and codes for the multi-buffer sample capture block
// request and response beat structs, command and result kind codes
// no dependencies
package mbsc_pkg;

   localparam int SAMPLE_W  = 32;
   localparam int BUF_NUM_W = 4;
   localparam int CNT_W     = 32;
   localparam int KIND_W    = 2;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   localparam logic [KIND_W-1:0] KIND_STORED  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DRAINED = 2'd2;
   localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd3;

   typedef struct packed {
      logic                       cmd;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic signed [SAMPLE_W-1:0] data_word;
      logic [BUF_NUM_W-1:0]       buffer_number;
      logic                       last;
      logic [CNT_W-1:0]           total_count;
      logic [CNT_W-1:0]           lost_count;
   } rsp_type;

   typedef struct packed {
      logic go;
      logic want_full;
   } scan_ctl_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_sts_type;

endpackage

// ===== sv/mbsc_ram.sv =====
// mbsc_ram: sample storage, one write port and one registered read port
// depends on mbsc_pkg for the sample width
module mbsc_ram #(
   parameter int DEPTH = 96
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [mbsc_pkg::SAMPLE_W-1:0]       wr_data,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [mbsc_pkg::SAMPLE_W-1:0]       rd_data
);
   import mbsc_pkg::*;

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mbsc_ring_scan.sv =====
// mbsc_ring_scan: round-robin search over the buffer flags, one buffer a cycle
// shared by the free-buffer search and the full-buffer search; uses mbsc_pkg
module mbsc_ring_scan #(
   parameter int BUFFER_NUM = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mbsc_pkg::scan_ctl_type            ctl,
   input  logic [BUFFER_NUM-1:0]             flags,
   input  logic [$clog2(BUFFER_NUM)-1:0]     start_idx,
   output mbsc_pkg::scan_sts_type            sts,
   output logic [$clog2(BUFFER_NUM)-1:0]     hit_idx
);
   import mbsc_pkg::*;

   localparam int IDX_W = $clog2(BUFFER_NUM);

   logic             run_ff,  run_in;
   logic             want_ff, want_in;
   logic [IDX_W-1:0] idx_ff,  idx_in;
   logic [IDX_W-1:0] cnt_ff,  cnt_in;
   logic             match;

   always_comb begin
      match     = (flags[idx_ff] == want_ff);
      sts.found = run_ff && match;
      sts.done  = run_ff && (match || (cnt_ff == IDX_W'(BUFFER_NUM - 1)));
      hit_idx   = idx_ff;

      run_in  = run_ff;
      want_in = want_ff;
      idx_in  = idx_ff;
      cnt_in  = cnt_ff;
      if (ctl.go) begin
         run_in  = 1'b1;
         want_in = ctl.want_full;
         idx_in  = start_idx;
         cnt_in  = '0;
      end else if (sts.done) begin
         run_in = 1'b0;
      end else if (run_ff) begin
         idx_in = (idx_ff == IDX_W'(BUFFER_NUM - 1)) ? '0 : idx_ff + 1'b1;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      want_ff <= want_in;
      idx_ff  <= idx_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// ===== sv/multi_buffer_sample_capture.sv =====
// multi_buffer_sample_capture: ring of sample buffers between an adc and a drain
// store: written to the active buffer with room; else that buffer is marked full and a
// free-buffer search runs first, and with no free buffer the sample is dropped; drain:
// a full-buffer search, then one word a cycle from the ram read port, or an empty
// result when nothing is full; results are registered; the receiver cannot stall them
// synchronous reset clears flags, pointers and counters; the sample ram is not cleared
module multi_buffer_sample_capture #(
   parameter int BUFFER_NUM      = 3,
   parameter int SAMPLES_PER_BUF = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mbsc_pkg::req_type req,
   output logic              rsp_valid,
   output mbsc_pkg::rsp_type rsp
);
   import mbsc_pkg::*;

   localparam int IDX_W  = $clog2(BUFFER_NUM);
   localparam int FILL_W = $clog2(SAMPLES_PER_BUF + 1);
   localparam int DEPTH  = BUFFER_NUM * SAMPLES_PER_BUF;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_SCAN_FREE = 5'b00010,
      ST_WRITE     = 5'b00100,
      ST_SCAN_FULL = 5'b01000,
      ST_DRAIN     = 5'b10000
   } state_type;

   state_type             state_ff,     state_in;
   req_type               req_ff,       req_in;
   logic [BUFFER_NUM-1:0] full_ff,      full_in;
   logic [IDX_W-1:0]      active_ff,    active_in;
   logic [FILL_W-1:0]     fill_ff,      fill_in;
   logic [IDX_W-1:0]      drain_ff,     drain_in;
   logic [CNT_W-1:0]      total_ff,     total_in;
   logic [CNT_W-1:0]      lost_ff,      lost_in;
   logic [FILL_W-1:0]     word_ff,      word_in;
   logic [IDX_W-1:0]      dbuf_ff,      dbuf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_drain_ff, rsp_drain_in;
   rsp_type               rsp_ff,       rsp_in;

   scan_ctl_type        scan_ctl;
   scan_sts_type        scan_sts;
   logic [IDX_W-1:0]    scan_start;
   logic [IDX_W-1:0]    scan_hit;
   logic                wr_en;
   logic                rd_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   logic                drain_last;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
      ring_next = (idx == IDX_W'(BUFFER_NUM - 1)) ? '0 : idx + 1'b1;
   endfunction

   mbsc_ring_scan #(
      .BUFFER_NUM (BUFFER_NUM)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .flags     (full_ff),
      .start_idx (scan_start),
      .sts       (scan_sts),
      .hit_idx   (scan_hit)
   );

   mbsc_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_ff.sample),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign wr_addr    = ADDR_W'(int'(active_ff) * SAMPLES_PER_BUF + int'(fill_ff));
   assign rd_addr    = ADDR_W'(int'(dbuf_ff) * SAMPLES_PER_BUF + int'(word_ff));
   assign drain_last = (word_ff == FILL_W'(SAMPLES_PER_BUF - 1));
   assign busy       = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      full_in      = full_ff;
      active_in    = active_ff;
      fill_in      = fill_ff;
      drain_in     = drain_ff;
      total_in     = total_ff;
      lost_in      = lost_ff;
      word_in      = word_ff;
      dbuf_in      = dbuf_ff;
      rsp_valid_in = 1'b0;
      rsp_drain_in = 1'b0;
      rsp_in       = rsp_ff;
      scan_ctl     = '0;
      scan_start   = '0;
      wr_en        = 1'b0;
      rd_en        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req;
               if (req.cmd == CMD_STORE) begin
                  if (fill_ff >= FILL_W'(SAMPLES_PER_BUF)) begin
                     full_in[active_ff] = 1'b1;
                     scan_ctl.go        = 1'b1;
                     scan_ctl.want_full = 1'b0;
                     scan_start         = ring_next(active_ff);
                     state_in           = ST_SCAN_FREE;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end else begin
                  scan_ctl.go        = 1'b1;
                  scan_ctl.want_full = 1'b1;
                  scan_start         = drain_ff;
                  state_in           = ST_SCAN_FULL;
               end
            end
         end
         ST_SCAN_FREE: begin
            if (scan_sts.done) begin
               if (scan_sts.found) begin
                  active_in = scan_hit;
                  fill_in   = '0;
                  state_in  = ST_WRITE;
               end else begin
                  lost_in              = lost_ff + 1'b1;
                  rsp_valid_in         = 1'b1;
                  rsp_in.kind          = KIND_DROPPED;
                  rsp_in.data_word     = '0;
                  rsp_in.buffer_number = BUF_NUM_W'(active_ff);
                  rsp_in.last          = 1'b1;
                  rsp_in.total_count   = total_ff;
                  rsp_in.lost_count    = lost_ff + 1'b1;
                  state_in             = ST_IDLE;
               end
            end
         end
         ST_WRITE: begin
            wr_en                = 1'b1;
            fill_in              = fill_ff + 1'b1;
            total_in             = total_ff + 1'b1;
            rsp_valid_in         = 1'b1;
            rsp_in.kind          = KIND_STORED;
            rsp_in.data_word     = '0;
            rsp_in.buffer_number = BUF_NUM_W'(active_ff);
            rsp_in.last          = 1'b1;
            rsp_in.total_count   = total_ff + 1'b1;
            rsp_in.lost_count    = lost_ff;
            state_in             = ST_IDLE;
         end
         ST_SCAN_FULL: begin
            if (scan_sts.done) begin
               if (scan_sts.found) begin
                  dbuf_in  = scan_hit;
                  word_in  = '0;
                  state_in = ST_DRAIN;
               end else begin
                  rsp_valid_in         = 1'b1;
                  rsp_in.kind          = KIND_EMPTY;
                  rsp_in.data_word     = '0;
                  rsp_in.buffer_number = '0;
                  rsp_in.last          = 1'b1;
                  rsp_in.total_count   = total_ff;
                  rsp_in.lost_count    = lost_ff;
                  state_in             = ST_IDLE;
               end
            end
         end
         ST_DRAIN: begin
            rd_en                = 1'b1;
            rsp_valid_in         = 1'b1;
            rsp_drain_in         = 1'b1;
            rsp_in.kind          = KIND_DRAINED;
            rsp_in.data_word     = '0;
            rsp_in.buffer_number = BUF_NUM_W'(dbuf_ff);
            rsp_in.last          = drain_last;
            rsp_in.total_count   = total_ff;
            rsp_in.lost_count    = lost_ff;
            word_in              = word_ff + 1'b1;
            if (drain_last) begin
               full_in[dbuf_ff] = 1'b0;
               if (dbuf_ff == active_ff) begin
                  fill_in = '0;
               end
               drain_in = ring_next(dbuf_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         full_ff      <= '0;
         active_ff    <= '0;
         fill_ff      <= '0;
         drain_ff     <= '0;
         total_ff     <= '0;
         lost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_drain_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         full_ff      <= full_in;
         active_ff    <= active_in;
         fill_ff      <= fill_in;
         drain_ff     <= drain_in;
         total_ff     <= total_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_drain_ff <= rsp_drain_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      word_ff <= word_in;
      dbuf_ff <= dbuf_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      rsp           = rsp_ff;
      rsp.data_word = rsp_drain_ff ? rd_data : '0;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
